>>> sv/pli_pkg.sv
package pli_pkg;

   localparam int DEFAULT_CAPACITY   = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // wide enough for any position up to the largest capacity
   localparam int POS_W = 11;

   localparam int OP_W     = 3;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic             shift_up;
      logic             shift_down;
      logic [POS_W-1:0] pos;
   } cmd_type;

endpackage

>>> sv/positional_list_insert_remove.sv
// the response to an accepted request sits in the output register from the next cycle on
// throughput: one transaction per cycle while rsp_tready is high; every cell updates in parallel with the others
// the response register frees up in the same cycle it is taken, so no bubbles appear
// reset clears the element count and the response valid; cell contents are left as is
module positional_list_insert_remove #(
   parameter int CAPACITY   = pli_pkg::DEFAULT_CAPACITY,
   parameter int DATA_WIDTH = pli_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] operation, [7:3] index, [39:8] value
   input  logic [pli_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
   output logic [pli_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import pli_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   op_type                   op;
   logic [INDEX_W-1:0]       idx;
   logic [VALUE_W-1:0]       value;
   logic [POS_W-1:0]         idx_ext;
   logic [POS_W-1:0]         cnt_ext;
   logic                     full;
   logic                     req_acc;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [VALUE_W-1:0]       rsp_read_value_ff;

   status_type               status;
   logic                     do_read;
   logic                     shift_up;
   logic                     shift_down;
   logic [POS_W-1:0]         pos;
   cmd_type                  cmd;

   logic signed [63:0]       value_64;
   logic [DATA_WIDTH-1:0]    store_value;
   logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0]    rd_bus [CAPACITY];
   logic [DATA_WIDTH-1:0]    rd_or;
   logic signed [DATA_WIDTH-1:0] rd_signed;
   logic signed [63:0]       rd_64;
   logic [VALUE_W-1:0]       rd_value;

   assign op      = op_type'(req_tdata[2:0]);
   assign idx     = req_tdata[7:3];
   assign value   = req_tdata[39:8];
   assign idx_ext = POS_W'(idx);
   assign cnt_ext = POS_W'(count_ff);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      status     = ST_DONE;
      do_read    = 1'b0;
      shift_up   = 1'b0;
      shift_down = 1'b0;
      pos        = idx_ext;
      count_in   = count_ff;
      case (op)
         OP_APPEND: begin
            pos = cnt_ext;
            if (full) begin
               status = ST_FULL;
            end else begin
               shift_up = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (idx_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               shift_up = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (idx_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               shift_down = 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ: begin
            if (idx_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               do_read = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd.shift_up   = shift_up && req_acc;
   assign cmd.shift_down = shift_down && req_acc;
   assign cmd.pos        = pos;

   // sign-extend the 32-bit value, keep the element width
   assign value_64    = 64'(signed'(value));
   assign store_value = value_64[DATA_WIDTH-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = store_value;
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end
      pli_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .POS        (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .value      (store_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .rd_data    (rd_bus[i])
      );
   end

   // at most one cell drives a nonzero word
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | rd_bus[i];
      end
   end

   assign rd_signed = signed'(rd_or);
   assign rd_64     = 64'(rd_signed);
   assign rd_value  = do_read ? rd_64[VALUE_W-1:0] : '0;

   assign rsp_valid_in = req_acc || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_status_ff     <= status;
         rsp_count_ff      <= COUNT_W'(count_in);
         rsp_read_value_ff <= rd_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_read_value_ff, rsp_count_ff, rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_FULL |-> rsp_count_ff == COUNT_W'(CAPACITY))
      else $error("full status with list not full");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_DONE |-> rsp_read_value_ff == '0)
      else $error("read value on rejected transaction");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_acc) |-> $stable(count_ff))
      else $error("count changed without a transaction");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_count_ff == COUNT_W'(count_ff))
      else $error("response count differs from list count");

endmodule

>>> sv/pli_cell.sv
module pli_cell #(
   parameter int DATA_WIDTH = pli_pkg::DEFAULT_DATA_WIDTH,
   parameter int POS        = 0
) (
   input  logic                    clock,
   input  pli_pkg::cmd_type        cmd,
   input  logic [DATA_WIDTH-1:0]   value,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   output logic [DATA_WIDTH-1:0]   data,
   output logic [DATA_WIDTH-1:0]   rd_data
);
   import pli_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (cmd.pos == POS_W'(POS));
   assign above_pos = (POS_W'(POS) > cmd.pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (above_pos) begin
            data_in = left_data;
         end else if (at_pos) begin
            data_in = value;
         end
      end else if (cmd.shift_down) begin
         if (above_pos || at_pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // only the addressed cell drives the read bus
   assign rd_data = at_pos ? data_ff : '0;

endmodule
